// ===== sv/sclru_pkg.sv =====
package sclru_pkg;

   localparam int ENTRIES = 32;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int ADDR_W  = 32;
   localparam int TIME_W  = 32;
   localparam int SLOT_W  = 5;
   localparam int KIND_W  = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TOUCH  = 2'd2;

   // lookup travelling down the row of slot cells
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic              hit;
      logic              have_free;
      logic              have_old;
      logic [TIME_W-1:0] best_age;
      logic [IDX_W-1:0]  victim;
      logic [ADDR_W-1:0] victim_tag;
   } scan_type;

   // slot update broadcast to all cells
   typedef struct packed {
      logic              en;
      logic              stamp_only;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] tag;
      logic [TIME_W-1:0] stamp;
   } wr_type;

endpackage

// ===== sv/sclru_cell.sv =====
module sclru_cell
   import sclru_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [IDX_W-1:0]  my_idx,
   input  logic [TIME_W-1:0] now,
   input  wr_type            wr,
   input  scan_type          pkt_i,
   output scan_type          pkt_o
);

   logic              valid_ff;
   logic [ADDR_W-1:0] tag_ff;
   logic [TIME_W-1:0] stamp_ff;
   scan_type          pkt_ff;
   scan_type          pkt_in;
   logic [TIME_W-1:0] age;

   assign age = now - stamp_ff;

   always_comb begin
      pkt_in = pkt_i;
      if (pkt_i.valid && !pkt_i.hit) begin
         if (valid_ff && tag_ff == pkt_i.addr) begin
            pkt_in.hit    = 1'b1;
            pkt_in.victim = my_idx;
         end else if (!valid_ff) begin
            if (!pkt_i.have_free) begin
               pkt_in.have_free = 1'b1;
               pkt_in.victim    = my_idx;
            end
         end else if (!pkt_i.have_free) begin
            if (!pkt_i.have_old || age > pkt_i.best_age) begin
               pkt_in.have_old   = 1'b1;
               pkt_in.best_age   = age;
               pkt_in.victim     = my_idx;
               pkt_in.victim_tag = tag_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pkt_ff   <= '0;
      end else begin
         pkt_ff <= pkt_in;
         if (wr.en && wr.idx == my_idx && !wr.stamp_only) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.idx == my_idx) begin
         stamp_ff <= wr.stamp;
         if (!wr.stamp_only) begin
            tag_ff <= wr.tag;
         end
      end
   end

   assign pkt_o = pkt_ff;

endmodule

// ===== sv/sample_cache_lru_allocator.sv =====
// Fully associative sample tag store of ENTRIES slots with LRU replacement.
// A tick transfer advances the 32-bit time counter, a touch transfer restamps
// one slot; both answer in the cycle after they are taken. A lookup walks a
// row of slot cells, one cell per clock; its result is captured for the
// FINISH state and then registered as the answer: a hit returns the lowest
// matching slot, a miss takes the first empty slot or else the oldest one
// (lowest index on ties), stamps it and reports any evicted address. One
// item is in flight at a time; a new one is taken once the previous result
// has been handed over or is leaving the output register.
module sample_cache_lru_allocator
   import sclru_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // sample_address[31:0], slot_in[36:32], 0
   input  logic [KIND_W-1:0]     req_tuser,  // kind[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // slot_out[4:0], hit[5], evicted[6],
                                             // old_address[38:7], 0
);

   typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_type;

   state_type             state_ff, state_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   scan_type              fin_ff, fin_in;
   wr_type                wr;
   logic                  accept;
   logic                  out_free;
   logic [ADDR_W-1:0]     req_addr;
   logic [SLOT_W-1:0]     req_slot;
   logic                  evict;
   scan_type              pkt [0:ENTRIES];

   function automatic logic [RSP_DATA_W-1:0] pack_rsp(logic [SLOT_W-1:0] slot, logic hit,
                                                      logic ev, logic [ADDR_W-1:0] old);
      return {1'b0, old, ev, hit, slot};
   endfunction

   assign req_addr   = req_tdata[ADDR_W-1:0];
   assign req_slot   = req_tdata[ADDR_W+SLOT_W-1:ADDR_W];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign evict      = !fin_ff.hit && !fin_ff.have_free;

   always_comb begin
      pkt[0]       = '0;
      pkt[0].valid = accept && req_tuser == KIND_LOOKUP;
      pkt[0].addr  = req_addr;
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      sclru_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .my_idx (IDX_W'(i)),
         .now    (now_ff),
         .wr     (wr),
         .pkt_i  (pkt[i]),
         .pkt_o  (pkt[i+1])
      );
   end

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      fin_in       = fin_ff;
      wr           = '0;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               unique case (req_tuser)
                  KIND_TICK: begin
                     now_in       = now_ff + 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pack_rsp('0, 1'b0, 1'b0, '0);
                  end
                  KIND_LOOKUP: begin
                     state_in = SCAN;
                  end
                  KIND_TOUCH: begin
                     wr.en         = 32'(req_slot) < ENTRIES;
                     wr.stamp_only = 1'b1;
                     wr.idx        = IDX_W'(req_slot);
                     wr.stamp      = now_ff;
                     rsp_valid_in  = 1'b1;
                     rsp_data_in   = pack_rsp(req_slot, 1'b0, 1'b0, '0);
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pack_rsp('0, 1'b0, 1'b0, '0);
                  end
               endcase
            end
         end
         SCAN: begin
            if (pkt[ENTRIES].valid) begin
               fin_in   = pkt[ENTRIES];
               state_in = FINISH;
            end
         end
         FINISH: begin
            if (out_free) begin
               wr.en         = !fin_ff.hit;
               wr.stamp_only = 1'b0;
               wr.idx        = fin_ff.victim;
               wr.tag        = fin_ff.addr;
               wr.stamp      = now_ff;
               rsp_valid_in  = 1'b1;
               rsp_data_in   = pack_rsp(SLOT_W'(fin_ff.victim), fin_ff.hit, evict,
                                        evict ? fin_ff.victim_tag : '0);
               state_in      = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      fin_ff      <= fin_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== sv/sclru_checker.sv =====
module sclru_checker
   import sclru_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[5] && rsp_tdata[6]))
      else $error("hit and eviction reported together");

   a_old_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[6] |-> rsp_tdata[38:7] == '0)
      else $error("old address without eviction");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind sample_cache_lru_allocator sclru_checker u_sclru_checker (.*);
